// ----- rtl/ipv4apsc_pkg.sv -----
package ipv4apsc_pkg;

    typedef enum logic [1:0] {
        VERDICT_NONE    = 2'd0,
        VERDICT_PARTIAL = 2'd1,
        VERDICT_EXACT   = 2'd2
    } t_verdict;

    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_DOT   = 8'd46;
    localparam logic [7:0] CH_SLASH = 8'd47;

    localparam logic [11:0] SEG_VALUE_MAX  = 12'd255;
    localparam logic [2:0]  SEG_DIGITS_MAX = 3'd3;
    localparam logic [2:0]  SEG_LEN_SAT    = 3'd4;
    localparam logic [1:0]  DOTS_MAX       = 2'd3;
    localparam logic [5:0]  LEN_MAX        = 6'd32;
    localparam logic [5:0]  LEN_SAT        = 6'd33;

endpackage

// ----- rtl/ipv4_address_prefix_syntax_check_core.sv -----
// an end-mark word sets o_valid as it leaves the input register
// throughput: one word per cycle unless stalled; a character word never produces output
// the input register drains while the output register is free or being taken
// synchronous active-low reset clears prefix mode, per-string state and both valid flags
module ipv4_address_prefix_syntax_check_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_ch,
    input  logic       i_end_mark,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_verdict
);
    import ipv4apsc_pkg::*;

    logic       r_prefix_mode;
    logic       r_in_valid;
    logic [7:0] r_ch;
    logic       r_end;
    logic       r_out_valid;
    t_verdict   r_verdict;

    logic       r_failed;
    logic [1:0] r_dot_count;
    logic       r_dot_pending;
    logic [2:0] r_seg_len;
    logic [9:0] r_seg_value;
    logic       r_in_length_part;
    logic       r_length_has_digit;
    logic [5:0] r_length_value;

    logic       n_failed;
    logic [1:0] n_dot_count;
    logic       n_dot_pending;
    logic [2:0] n_seg_len;
    logic [9:0] n_seg_value;
    logic       n_in_length_part;
    logic       n_length_has_digit;
    logic [5:0] n_length_value;

    logic       out_free;
    logic       advance;
    logic       accept;
    logic       is_digit;
    logic [3:0] digit_val;
    logic [11:0] seg_sum;
    logic [8:0]  len_sum;
    t_verdict   verdict_now;

    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && (!r_end || out_free);
    assign o_stall  = r_in_valid && !advance;
    assign accept   = i_valid && !o_stall;

    assign is_digit  = (r_ch >= CH_ZERO) && (r_ch <= CH_NINE);
    assign digit_val = r_ch[3:0];
    assign seg_sum   = ({2'b00, r_seg_value} * 12'd10) + {8'd0, digit_val};
    assign len_sum   = ({3'b000, r_length_value} * 9'd10) + {5'd0, digit_val};

    always_comb begin
        if (r_failed) begin
            verdict_now = VERDICT_NONE;
        end else if (r_in_length_part) begin
            if (!r_length_has_digit) begin
                verdict_now = VERDICT_PARTIAL;
            end else if (r_length_value <= LEN_MAX) begin
                verdict_now = VERDICT_EXACT;
            end else begin
                verdict_now = VERDICT_NONE;
            end
        end else if (r_prefix_mode) begin
            verdict_now = VERDICT_PARTIAL;
        end else if (r_dot_count == DOTS_MAX && r_seg_len != 3'd0 && !r_dot_pending) begin
            verdict_now = VERDICT_EXACT;
        end else begin
            verdict_now = VERDICT_PARTIAL;
        end
    end

    always_comb begin
        n_failed           = r_failed;
        n_dot_count        = r_dot_count;
        n_dot_pending      = r_dot_pending;
        n_seg_len          = r_seg_len;
        n_seg_value        = r_seg_value;
        n_in_length_part   = r_in_length_part;
        n_length_has_digit = r_length_has_digit;
        n_length_value     = r_length_value;
        if (r_end) begin
            n_failed           = 1'b0;
            n_dot_count        = 2'd0;
            n_dot_pending      = 1'b0;
            n_seg_len          = 3'd0;
            n_seg_value        = 10'd0;
            n_in_length_part   = 1'b0;
            n_length_has_digit = 1'b0;
            n_length_value     = 6'd0;
        end else if (r_failed) begin
            n_failed = 1'b1;
        end else if (r_in_length_part) begin
            if (!is_digit) begin
                n_failed = 1'b1;
            end else begin
                n_length_has_digit = 1'b1;
                n_length_value     = (len_sum > {3'b000, LEN_SAT}) ? LEN_SAT : len_sum[5:0];
            end
        end else if (is_digit) begin
            n_dot_pending = 1'b0;
            if (r_seg_len >= SEG_DIGITS_MAX) begin
                n_seg_len = SEG_LEN_SAT;
                n_failed  = 1'b1;
            end else begin
                n_seg_len   = r_seg_len + 3'd1;
                n_seg_value = seg_sum[9:0];
                n_failed    = (seg_sum > SEG_VALUE_MAX);
            end
        end else if (r_ch == CH_DOT) begin
            if (r_seg_len == 3'd0 || r_dot_count == DOTS_MAX) begin
                n_failed = 1'b1;
            end else begin
                n_dot_count   = r_dot_count + 2'd1;
                n_seg_len     = 3'd0;
                n_seg_value   = 10'd0;
                n_dot_pending = 1'b1;
            end
        end else if (r_ch == CH_SLASH && r_prefix_mode) begin
            if (r_seg_len == 3'd0 || r_dot_count != DOTS_MAX) begin
                n_failed = 1'b1;
            end else begin
                n_in_length_part = 1'b1;
                n_dot_pending    = 1'b0;
            end
        end else begin
            n_failed = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix_mode      <= 1'b0;
            r_in_valid         <= 1'b0;
            r_out_valid        <= 1'b0;
            r_failed           <= 1'b0;
            r_dot_count        <= 2'd0;
            r_dot_pending      <= 1'b0;
            r_seg_len          <= 3'd0;
            r_seg_value        <= 10'd0;
            r_in_length_part   <= 1'b0;
            r_length_has_digit <= 1'b0;
            r_length_value     <= 6'd0;
        end else begin
            if (i_cfg_wr_en) begin
                r_prefix_mode <= i_cfg_wr_data;
            end
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance && r_end) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (advance) begin
                r_failed           <= n_failed;
                r_dot_count        <= n_dot_count;
                r_dot_pending      <= n_dot_pending;
                r_seg_len          <= n_seg_len;
                r_seg_value        <= n_seg_value;
                r_in_length_part   <= n_in_length_part;
                r_length_has_digit <= n_length_has_digit;
                r_length_value     <= n_length_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ch  <= i_ch;
            r_end <= i_end_mark;
        end
        if (advance && r_end) begin
            r_verdict <= verdict_now;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_verdict = r_verdict;

    // state is clean after a verdict word
    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_end) |=> (!r_failed && r_dot_count == 2'd0 && r_seg_len == 3'd0
                                && !r_in_length_part && !r_length_has_digit))
        else $error("string state not cleared after verdict");

    a_seg_len_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seg_len > SEG_DIGITS_MAX) |-> r_failed)
        else $error("overlong segment without failure");

    a_length_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_length_value <= LEN_SAT)
        else $error("length value beyond saturation");

    a_length_after_dots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_length_part |-> (r_dot_count == DOTS_MAX))
        else $error("length part entered before third dot");

    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_verdict == VERDICT_NONE || o_verdict == VERDICT_PARTIAL
                     || o_verdict == VERDICT_EXACT))
        else $error("reserved verdict code on output");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;

    import ipv4apsc_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int N_DIR       = 13;

    typedef struct packed {
        logic [79:0] text;
        logic [3:0]  len;
        logic        mode;
        logic        typed;
        t_verdict    verdict;
    } t_dir_row;

    typedef struct packed {
        logic       failed;
        logic [1:0] dots;
        logic       dot_pend;
        logic [2:0] seg_len;
        logic [9:0] seg_val;
        logic       in_len;
        logic       len_digit;
        logic [5:0] len_val;
    } t_scan_state;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic       i_cfg_wr_data;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_ch;
    logic       i_end_mark;
    logic       o_valid;
    logic       i_stall;
    logic [1:0] o_verdict;

    t_verdict    verdict_q [$];
    logic [7:0]  line_q [$];
    t_scan_state scan;
    logic        mode_now;
    int          words_sent;
    int          errors;
    int          cycles;
    int          src_idle_pct;
    int          snk_stall_pct;

    t_dir_row dir_tab [N_DIR] = '{
        '{"",           4'd0,  1'b0, 1'b1, VERDICT_PARTIAL},
        '{"255.0.9.1",  4'd9,  1'b0, 1'b1, VERDICT_EXACT},
        '{".",          4'd1,  1'b0, 1'b1, VERDICT_NONE},
        '{"1234",       4'd4,  1'b0, 1'b1, VERDICT_NONE},
        '{"256",        4'd3,  1'b0, 1'b1, VERDICT_NONE},
        '{"1.",         4'd2,  1'b0, 1'b1, VERDICT_PARTIAL},
        '{"1/",         4'd2,  1'b0, 1'b1, VERDICT_NONE},
        '{80'h00,       4'd1,  1'b0, 1'b1, VERDICT_NONE},
        '{80'hff,       4'd1,  1'b0, 1'b1, VERDICT_NONE},
        '{"",           4'd0,  1'b1, 1'b1, VERDICT_PARTIAL},
        '{"1.2/",       4'd4,  1'b1, 1'b1, VERDICT_NONE},
        '{"1.2.3.4/",   4'd8,  1'b1, 1'b0, VERDICT_NONE},
        '{"1.2.3.4/40", 4'd10, 1'b1, 1'b0, VERDICT_NONE}
    };

    ipv4_address_prefix_syntax_check_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_ch          (i_ch),
        .i_end_mark    (i_end_mark),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_verdict     (o_verdict)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void scan_char(input logic [7:0] c);
        logic is_dig;
        int   d;
        int   v;
        is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
        d = is_dig ? int'(c - CH_ZERO) : 0;
        if (scan.failed) begin
        end else if (scan.in_len) begin
            if (!is_dig) begin
                scan.failed = 1'b1;
            end else begin
                scan.len_digit = 1'b1;
                v = scan.len_val * 10 + d;
                if (v > LEN_SAT) v = LEN_SAT;
                scan.len_val = v[5:0];
            end
        end else if (is_dig) begin
            scan.dot_pend = 1'b0;
            if (scan.seg_len >= SEG_DIGITS_MAX) begin
                scan.seg_len = SEG_LEN_SAT;
                scan.failed = 1'b1;
            end else begin
                scan.seg_len = scan.seg_len + 3'd1;
                v = scan.seg_val * 10 + d;
                scan.seg_val = v[9:0];
                if (v > SEG_VALUE_MAX) scan.failed = 1'b1;
            end
        end else if (c == CH_DOT) begin
            if (scan.seg_len == 3'd0 || scan.dots >= DOTS_MAX) begin
                scan.failed = 1'b1;
            end else begin
                scan.dots = scan.dots + 2'd1;
                scan.seg_len = 3'd0;
                scan.seg_val = 10'd0;
                scan.dot_pend = 1'b1;
            end
        end else if (c == CH_SLASH && mode_now) begin
            if (scan.seg_len == 3'd0 || scan.dots < DOTS_MAX) begin
                scan.failed = 1'b1;
            end else begin
                scan.in_len = 1'b1;
                scan.dot_pend = 1'b0;
            end
        end else begin
            scan.failed = 1'b1;
        end
    endfunction

    function automatic t_verdict address_verdict();
        if (scan.failed) return VERDICT_NONE;
        if (scan.in_len) begin
            if (!scan.len_digit) return VERDICT_PARTIAL;
            return (scan.len_val <= LEN_MAX) ? VERDICT_EXACT : VERDICT_NONE;
        end
        if (mode_now) return VERDICT_PARTIAL;
        if (scan.dots == DOTS_MAX && scan.seg_len != 3'd0 && !scan.dot_pend)
            return VERDICT_EXACT;
        return VERDICT_PARTIAL;
    endfunction

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(0, 255));
            1: return CH_DOT;
            2: return CH_SLASH;
            default: return CH_ZERO + 8'($urandom_range(0, 9));
        endcase
    endfunction

    function automatic void push_number(input int val);
        string s;
        s = $sformatf("%0d", val);
        for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
    endfunction

    // mostly well-formed addresses with random content, then damage some of them
    function automatic void build_line();
        int n;
        int pos;
        line_q.delete();
        if ($urandom_range(0, 99) < 10) begin
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++) line_q.push_back(pick_char());
        end else begin
            for (int s = 0; s < 4; s++) begin
                if (s != 0) line_q.push_back(CH_DOT);
                if ($urandom_range(0, 19) == 0) line_q.push_back(CH_ZERO);
                push_number(($urandom_range(0, 9) == 0) ? $urandom_range(0, 999)
                                                        : $urandom_range(0, 255));
            end
            if (mode_now || $urandom_range(0, 9) == 0) begin
                line_q.push_back(CH_SLASH);
                if ($urandom_range(0, 9) != 0)
                    push_number(($urandom_range(0, 9) == 0) ? $urandom_range(0, 999)
                                                            : $urandom_range(0, 40));
            end
            if ($urandom_range(0, 99) < 15) begin
                pos = $urandom_range(0, line_q.size() - 1);
                line_q[pos] = pick_char();
            end
            if ($urandom_range(0, 99) < 5) begin
                pos = $urandom_range(0, line_q.size() - 1);
                line_q.insert(pos, CH_DOT);
            end
            if ($urandom_range(0, 99) < 15) begin
                n = $urandom_range(0, line_q.size());
                while (line_q.size() > n) void'(line_q.pop_back());
            end
        end
    endfunction

    task automatic send_word(input logic [7:0] ch, input logic em);
        @(negedge i_clk);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
            while ($urandom_range(0, 99) < src_idle_pct) @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_ch       <= ch;
        i_end_mark <= em;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic feed_word(input logic [7:0] ch, input logic em,
                             input logic typed, input t_verdict tv);
        send_word(ch, em);
        if (em) begin
            verdict_q.push_back(typed ? tv : address_verdict());
            scan = '0;
        end else begin
            scan_char(ch);
        end
    endtask

    // character words give no output, so wait on past the last verdict for them to drain
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (verdict_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= m;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        mode_now = m;
    endtask

    task automatic run_random(input int n_words);
        int stop_at;
        int flip_at;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at) begin
            build_line();
            flip_at = ($urandom_range(0, 19) == 0) ? $urandom_range(0, line_q.size()) : -1;
            for (int i = 0; i < line_q.size(); i++) begin
                if (i == flip_at) write_mode(!mode_now);
                feed_word(line_q[i], 1'b0, 1'b0, VERDICT_NONE);
            end
            feed_word(8'($urandom_range(0, 255)), 1'b1, 1'b0, VERDICT_NONE);
        end
    endtask

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < snk_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (verdict_q.size() == 0) begin
                $error("verdict: no word expected, actual %0d", o_verdict);
                errors++;
            end else if (o_verdict !== verdict_q[0]) begin
                $error("verdict: expected %0d, actual %0d", verdict_q[0], o_verdict);
                errors++;
                void'(verdict_q.pop_front());
            end else begin
                void'(verdict_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** ipv4_address_prefix_syntax_check_core: FAILED **");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 1'b0;
        i_valid       = 1'b0;
        i_ch          = 8'd0;
        i_end_mark    = 1'b0;
        i_stall       = 1'b0;
        scan          = '0;
        mode_now      = 1'b0;
        words_sent    = 0;
        errors        = 0;
        cycles        = 0;
        src_idle_pct  = 19;
        snk_stall_pct = 59;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_DIR; r++) begin
            int base;
            if (dir_tab[r].mode != mode_now) write_mode(dir_tab[r].mode);
            for (int k = 0; k < dir_tab[r].len; k++) begin
                base = 8 * (dir_tab[r].len - 1 - k);
                feed_word(dir_tab[r].text[base +: 8], 1'b0, 1'b0, VERDICT_NONE);
            end
            feed_word(8'($urandom_range(0, 255)), 1'b1, dir_tab[r].typed,
                      dir_tab[r].verdict);
        end

        write_mode(1'b0);
        run_random(200);

        src_idle_pct  = 59;
        snk_stall_pct = 19;
        write_mode(1'b1);
        run_random(200);

        src_idle_pct  = 0;
        snk_stall_pct = 0;
        write_mode(1'b0);
        run_random(200);

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("** ipv4_address_prefix_syntax_check_core: PASSED **");
        end else begin
            $display("** ipv4_address_prefix_syntax_check_core: FAILED **");
        end
        $finish;
    end

endmodule
